[design/i2a_pkg.sv]
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants of the integer to ascii formatter
// digit cell row sizes, operation codes, ascii codes and cell control
// ----------------------------------------------------------------------------
package i2a_pkg;

	localparam int VAL_W      = 32;  // value width
	localparam int OP_W       = 2;
	localparam int FW_W       = 6;   // field_width port width
	localparam int CHAR_W     = 8;
	localparam int DIG_W      = 4;   // one bcd or hex digit
	localparam int NUM_CELLS  = 10;  // enough decimal digits for 32 bits
	localparam int HEX_CELLS  = 8;
	localparam int CELL_IDX_W = 4;
	localparam int BIT_CNT_W  = 5;   // counts the 32 conversion shifts

	typedef enum logic [OP_W-1:0] {
		OP_SDEC = 2'd0,
		OP_UDEC = 2'd1,
		OP_HEXL = 2'd2,
		OP_HEXU = 2'd3
	} op_t;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

	localparam logic [DIG_W-1:0]  DEC_RADIX = 4'd10;
	localparam logic [DIG_W-1:0]  BCD_FIX_MIN = 4'd5;
	localparam logic [DIG_W-1:0]  BCD_FIX_ADD = 4'd3;

	typedef struct packed {
		logic load;   // take the load digit
		logic shift;  // one double dabble step
	} cell_ctrl_t;

endpackage

[design/i2a_if.sv]
// ----------------------------------------------------------------------------
// i2a_if: item channels of the integer to ascii formatter
// valid/ready channels for the input item and for the output characters
// ----------------------------------------------------------------------------
interface i2a_in_if;
	logic                           valid;
	logic                           ready;
	logic [i2a_pkg::OP_W-1:0]       operation;
	logic [i2a_pkg::VAL_W-1:0]      value;
	logic [i2a_pkg::FW_W-1:0]       field_width;
	logic                           zero_fill;
	logic                           hex_prefix;

	modport source (output valid, operation, value, field_width, zero_fill, hex_prefix,
		input ready);
	modport sink (input valid, operation, value, field_width, zero_fill, hex_prefix,
		output ready);
endinterface

interface i2a_out_if;
	logic                           valid;
	logic                           ready;
	logic [i2a_pkg::CHAR_W-1:0]     character;
	logic                           last_char;

	modport source (output valid, character, last_char, input ready);
	modport sink (input valid, character, last_char, output ready);
endinterface

[design/i2a_cell.sv]
// ----------------------------------------------------------------------------
// i2a_cell: one digit cell of the conversion row
// holds one digit; loads a hex nibble or takes one double dabble shift step
// ----------------------------------------------------------------------------
module i2a_cell (
	input  logic                          clk,
	input  i2a_pkg::cell_ctrl_t           ctrl,
	input  logic [i2a_pkg::DIG_W-1:0]     load_digit,
	input  logic                          carry_in,
	output logic                          carry_out,
	output logic [i2a_pkg::DIG_W-1:0]     digit
);

	logic [i2a_pkg::DIG_W-1:0] digit_q;
	logic [i2a_pkg::DIG_W-1:0] corr;

	// add 3 before the shift when the digit would reach ten or more
	assign corr      = (digit_q >= i2a_pkg::BCD_FIX_MIN) ? digit_q + i2a_pkg::BCD_FIX_ADD
		: digit_q;
	assign carry_out = corr[i2a_pkg::DIG_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			digit_q <= load_digit;
		end else if (ctrl.shift) begin
			digit_q <= {corr[i2a_pkg::DIG_W-2:0], carry_in};
		end
	end

endmodule

[design/integer_to_ascii_formatter_core.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core: printf style %d %u %x %X formatter
// turns one 32-bit value into its ascii characters, most significant first
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  din     | in  | valid / ready | operation, value, field_width, zero_fill, hex_prefix
//  dout    | out | valid / ready | character, last_char
//
//  decimal item: accept, double dabble shifts, plan, then its characters
//  hex item: accept, plan, then its characters (nibbles load directly)
//  the decimal double dabble pass runs 32 steps through the row of ten digit cells
//  din is taken only when the sequencer is idle; the last character may still wait in
//  the output register while the next item is taken
//  a stall on dout holds the output register and freezes character sequencing;
//  conversion and planning of a new item run on
//  arst_n clears the sequencer and the output valid; digit cells need no reset
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core #(
	parameter int MAX_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	i2a_in_if.sink       din,
	i2a_out_if.source    dout
);

	localparam int PAD_W = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W = PAD_W + 1;   // room for width minus used

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,    // double dabble shifts
		ST_PLAN,    // count digits and padding
		ST_PRE0,    // leading '-' or the '0' of the prefix
		ST_PRE1,    // 'x' or 'X'
		ST_PAD,
		ST_SIGN,    // '-' right before the digits
		ST_DIGIT
	} state_t;

	state_t                                 state_q;
	i2a_pkg::op_t                           op_q;
	logic                                   neg_q;
	logic                                   zeros_q;
	logic                                   prefix_q;
	logic [PAD_W-1:0]                       width_q;
	logic [i2a_pkg::VAL_W-1:0]              bin_q;
	logic [i2a_pkg::BIT_CNT_W-1:0]          bit_cnt_q;
	logic [PAD_W-1:0]                       pad_q;
	logic [i2a_pkg::CELL_IDX_W-1:0]         dptr_q;
	logic                                   out_valid_q;
	logic [i2a_pkg::CHAR_W-1:0]             out_char_q;
	logic                                   out_last_q;

	// cell row wiring
	i2a_pkg::cell_ctrl_t                    cell_ctrl;
	logic [i2a_pkg::DIG_W-1:0]              load_dig [i2a_pkg::NUM_CELLS];
	logic [i2a_pkg::DIG_W-1:0]              dig      [i2a_pkg::NUM_CELLS];
	logic [i2a_pkg::NUM_CELLS:0]            carry;

	logic                                   in_acc;
	logic                                   adv;
	logic                                   in_neg;
	logic [i2a_pkg::VAL_W-1:0]              in_mag;
	logic                                   is_hex;
	logic                                   upper;

	// planning results
	logic [i2a_pkg::CELL_IDX_W-1:0]         msd;
	logic [CMP_W-1:0]                       used;
	logic [PAD_W-1:0]                       pad_plan;

	// character sequencing
	logic [i2a_pkg::DIG_W-1:0]              cur_dig;
	logic [i2a_pkg::CHAR_W-1:0]             char_d;
	logic                                   last_d;
	state_t                                 nxt;
	state_t                                 after_pad_st;
	logic                                   emitting;

	assign din.ready      = (state_q == ST_IDLE);
	assign in_acc         = din.valid && din.ready;
	assign adv            = !out_valid_q || dout.ready;
	assign dout.valid     = out_valid_q;
	assign dout.character = out_char_q;
	assign dout.last_char = out_last_q;

	assign is_hex = op_q[1];
	assign upper  = (op_q == i2a_pkg::OP_HEXU);

	// magnitude of a negative signed value is its two's complement negation
	assign in_neg = (i2a_pkg::op_t'(din.operation) == i2a_pkg::OP_SDEC) &&
		din.value[i2a_pkg::VAL_W-1];
	assign in_mag = in_neg ? (~din.value + 1'b1) : din.value;

	// ---------------- digit cell row ----------------
	assign cell_ctrl.load  = in_acc;
	assign cell_ctrl.shift = (state_q == ST_CONV);
	assign carry[0]        = bin_q[i2a_pkg::VAL_W-1];

	always_comb begin
		for (int i = 0; i < i2a_pkg::NUM_CELLS; i++) begin
			load_dig[i] = '0;
		end
		// hex nibbles go straight into the cells, decimal starts from zero
		if (din.operation[1]) begin
			for (int i = 0; i < i2a_pkg::HEX_CELLS; i++) begin
				load_dig[i] = din.value[i*i2a_pkg::DIG_W +: i2a_pkg::DIG_W];
			end
		end
	end

	for (genvar g = 0; g < i2a_pkg::NUM_CELLS; g++) begin : g_cell
		i2a_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.load_digit (load_dig[g]),
			.carry_in   (carry[g]),
			.carry_out  (carry[g+1]),
			.digit      (dig[g])
		);
	end

	// ---------------- planning ----------------
	// highest nonzero digit; a zero value still prints one digit
	always_comb begin
		msd = '0;
		for (int i = 0; i < i2a_pkg::NUM_CELLS; i++) begin
			if (dig[i] != '0) begin
				msd = i2a_pkg::CELL_IDX_W'(i);
			end
		end
	end

	assign used     = CMP_W'(msd) + CMP_W'(1) + CMP_W'(neg_q);
	assign pad_plan = (CMP_W'(width_q) > used) ? PAD_W'(CMP_W'(width_q) - used) : '0;

	// ---------------- character selection ----------------
	assign cur_dig      = dig[dptr_q];
	assign after_pad_st = (neg_q && !zeros_q) ? ST_SIGN : ST_DIGIT;
	assign emitting     = (state_q == ST_PRE0) || (state_q == ST_PRE1) ||
		(state_q == ST_PAD) || (state_q == ST_SIGN) || (state_q == ST_DIGIT);

	always_comb begin
		char_d = i2a_pkg::CH_ZERO;
		last_d = 1'b0;
		nxt    = state_q;
		case (state_q)
			ST_PLAN: begin
				if ((is_hex && prefix_q) || (neg_q && zeros_q)) begin
					nxt = ST_PRE0;
				end else if (pad_plan != '0) begin
					nxt = ST_PAD;
				end else begin
					nxt = after_pad_st;
				end
			end
			ST_PRE0: begin
				char_d = is_hex ? i2a_pkg::CH_ZERO : i2a_pkg::CH_MINUS;
				if (is_hex) begin
					nxt = ST_PRE1;
				end else begin
					nxt = (pad_q != '0) ? ST_PAD : ST_DIGIT;
				end
			end
			ST_PRE1: begin
				char_d = upper ? i2a_pkg::CH_UX : i2a_pkg::CH_LX;
				nxt    = (pad_q != '0) ? ST_PAD : ST_DIGIT;
			end
			ST_PAD: begin
				char_d = zeros_q ? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE;
				nxt    = (pad_q == PAD_W'(1)) ? after_pad_st : ST_PAD;
			end
			ST_SIGN: begin
				char_d = i2a_pkg::CH_MINUS;
				nxt    = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (cur_dig < i2a_pkg::DEC_RADIX) begin
					char_d = i2a_pkg::CH_ZERO + i2a_pkg::CHAR_W'(cur_dig);
				end else begin
					char_d = (upper ? i2a_pkg::CH_UA : i2a_pkg::CH_LA) +
						i2a_pkg::CHAR_W'(cur_dig) - i2a_pkg::CHAR_W'(i2a_pkg::DEC_RADIX);
				end
				last_d = (dptr_q == '0);
				nxt    = last_d ? ST_IDLE : ST_DIGIT;
			end
			default: begin
				nxt = state_q;
			end
		endcase
	end

	// ---------------- sequencer and output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a taken character empties the register unless a new one follows
			if (adv && !emitting) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q      <= i2a_pkg::op_t'(din.operation);
						neg_q     <= in_neg;
						zeros_q   <= din.zero_fill;
						prefix_q  <= din.hex_prefix;
						// field width saturates at MAX_WIDTH
						width_q   <= (din.field_width > i2a_pkg::FW_W'(MAX_WIDTH))
							? PAD_W'(MAX_WIDTH) : PAD_W'(din.field_width);
						bin_q     <= in_mag;
						bit_cnt_q <= '0;
						state_q   <= din.operation[1] ? ST_PLAN : ST_CONV;
					end
				end
				ST_CONV: begin
					bin_q     <= {bin_q[i2a_pkg::VAL_W-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == '1) begin
						state_q <= ST_PLAN;
					end
				end
				ST_PLAN: begin
					pad_q   <= pad_plan;
					dptr_q  <= msd;
					state_q <= nxt;
				end
				default: begin
					if (emitting && adv) begin
						out_valid_q <= 1'b1;
						out_char_q  <= char_d;
						out_last_q  <= last_d;
						state_q     <= nxt;
						if (state_q == ST_PAD) begin
							pad_q <= pad_q - 1'b1;
						end
						if (state_q == ST_DIGIT && !last_d) begin
							dptr_q <= dptr_q - 1'b1;
						end
					end
				end
			endcase
		end
	end

endmodule

[design/i2a_checker.sv]
// ----------------------------------------------------------------------------
// i2a_checker: port level checks of the integer to ascii formatter
// watches both channels and is bound to the top level
// ----------------------------------------------------------------------------
module i2a_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [i2a_pkg::CHAR_W-1:0]    character,
	input logic                          last_char
);

	// a stalled character stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last_char))
		else $error("output item changed while stalled");

	// an accepted item does not reopen the input straight away
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input reopened too early");

	// while an unfinished value is on the output, no new item is taken
	a_no_accept_mid_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_char |-> !in_ready)
		else $error("input ready in the middle of a value");

	// only printable characters of the formatter's set
	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character >= i2a_pkg::CH_SPACE) && (character <= i2a_pkg::CH_LX))
		else $error("unexpected output character");

endmodule

bind integer_to_ascii_formatter_core i2a_checker u_i2a_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.character (dout.character),
	.last_char (dout.last_char)
);

[bench/i2a_char_checker.sv]
// ----------------------------------------------------------------------------
// i2a_char_checker: character scoreboard of the integer to ascii formatter
// watches both channels, formats every accepted item into its expected
// characters and compares each output character against the oldest one
// ----------------------------------------------------------------------------
module i2a_char_checker #(
	parameter int MAX_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	i2a_in_if    din,
	i2a_out_if   dout,
	output int   errors,
	output int   outstanding
);
	import i2a_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last_char;
	} char_exp_t;

	char_exp_t expected_chars[$];

	// printf style formatting of one item into the expected character queue
	function automatic void format_item(op_t op, logic [VAL_W-1:0] v, logic [FW_W-1:0] fw,
		logic zf, logic hp);
		logic [CHAR_W-1:0] digits[$];
		logic [CHAR_W-1:0] text[$];
		logic [CHAR_W-1:0] fill;
		logic [CHAR_W-1:0] alpha;
		logic [VAL_W-1:0]  mag;
		logic [DIG_W-1:0]  nib;
		logic              neg;
		int                span;
		int                used;
		int                pad;
		span = (fw > MAX_WIDTH) ? MAX_WIDTH : int'(fw);
		fill = zf ? CH_ZERO : CH_SPACE;
		neg  = (op == OP_SDEC) && v[VAL_W-1];
		mag  = neg ? (~v + 1'b1) : v;
		if (op == OP_SDEC || op == OP_UDEC) begin
			do begin
				digits.push_front(CH_ZERO + 8'(mag % DEC_RADIX));
				mag = mag / DEC_RADIX;
			end while (mag != 0);
			used = digits.size() + int'(neg);
			pad  = (span > used) ? span - used : 0;
			if (neg && zf)
				text.push_back(CH_MINUS);
			repeat (pad) text.push_back(fill);
			if (neg && !zf)
				text.push_back(CH_MINUS);
		end else begin
			alpha = (op == OP_HEXU) ? CH_UA : CH_LA;
			if (hp) begin
				text.push_back(CH_ZERO);
				text.push_back((op == OP_HEXU) ? CH_UX : CH_LX);
			end
			do begin
				nib = mag[DIG_W-1:0];
				digits.push_front((nib < DEC_RADIX) ? CH_ZERO + nib : alpha + nib - DEC_RADIX);
				mag = mag >> DIG_W;
			end while (mag != 0);
			used = digits.size();
			pad  = (span > used) ? span - used : 0;
			repeat (pad) text.push_back(fill);
		end
		foreach (digits[i]) text.push_back(digits[i]);
		foreach (text[i]) expected_chars.push_back('{text[i], i == text.size() - 1});
	endfunction

	always @(posedge clk) begin
		char_exp_t want;
		if (arst_n) begin
			if (din.valid && din.ready)
				format_item(op_t'(din.operation), din.value, din.field_width,
					din.zero_fill, din.hex_prefix);
			if (dout.valid && dout.ready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: character 0x%02h last %0b arrived with nothing expected",
						$time, dout.character, dout.last_char);
					errors++;
				end else begin
					want = expected_chars.pop_front();
					if (dout.character !== want.character) begin
						$display("%0t: character expected 0x%02h actual 0x%02h",
							$time, want.character, dout.character);
						errors++;
					end
					if (dout.last_char !== want.last_char) begin
						$display("%0t: last_char expected %0b actual %0b (character 0x%02h)",
							$time, want.last_char, dout.last_char, want.character);
						errors++;
					end
				end
			end
		end
		outstanding <= expected_chars.size();
	end

endmodule

[bench/integer_to_ascii_formatter_core_tb.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core_tb: testbench of the integer formatter
// directed corner items then random items through the input channel, with
// random gaps on the sender and random stalls on the character receiver;
// the checker beside the block predicts and compares every character
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core_tb;
	import i2a_pkg::*;

	localparam int MAX_WIDTH    = 32;
	localparam int RANDOM_ITEMS = 347;
	// longest quiet stretch of a correct run is a long sender gap plus a
	// decimal conversion, or one long receiver stall
	localparam int QUIET_LIMIT  = 2000;
	// a quiet tail once every expected character has come out
	localparam int TAIL_CYCLES  = 40;

	logic clk;
	logic arst_n;
	logic calm;        // no new gaps and no new stalls drawn while set
	int   errors;
	int   outstanding;
	int   quiet;
	int   stall_left;

	i2a_in_if  din();
	i2a_out_if dout();

	integer_to_ascii_formatter_core #(.MAX_WIDTH(MAX_WIDTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	i2a_char_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.din         (din),
		.dout        (dout),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// idle length: mostly none or short, now and then a long one
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// values biased toward digit count edges, the sign boundary and small numbers
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 99);
			2: return 32'h8000_0000 + $urandom_range(0, 2) - 1;
			3: return 32'd0 - 32'($urandom_range(1, 1000));
			4: return $urandom() >> $urandom_range(0, 31);
			default: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
		endcase
	endfunction

	// widths: mostly small so padding shows up often, sometimes past the saturation point
	function automatic logic [FW_W-1:0] pick_width();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return FW_W'($urandom_range(0, 12));
		if (r < 90)
			return FW_W'($urandom_range(0, 34));
		return FW_W'($urandom_range(0, 63));
	endfunction

	// one item on the input channel; valid stays high straight into the next
	// item when no gap is drawn, so it is never lowered and raised in one step
	task automatic send_item(input op_t op, input logic [VAL_W-1:0] v,
		input logic [FW_W-1:0] fw, input logic zf, input logic hp);
		int idle;
		idle = calm ? 0 : pick_idle();
		if (idle > 0) begin
			din.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		din.valid       <= 1'b1;
		din.operation   <= op;
		din.value       <= v;
		din.field_width <= fw;
		din.zero_fill   <= zf;
		din.hex_prefix  <= hp;
		@(posedge clk);
		while (!din.ready) @(posedge clk);
	endtask

	// hold the sender until every expected character has come out;
	// the extra edge lets the checker count the item just accepted
	task automatic wait_drained();
		din.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// character receiver with random stalls
	initial begin
		dout.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				dout.ready <= 1'b0;
			end else begin
				if (!calm && $urandom_range(0, 99) < 30)
					stall_left = pick_idle();
				dout.ready <= (stall_left == 0);
			end
		end
	end

	// watchdog: ends the run when nothing moves on either channel for too long
	initial quiet = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((din.valid && din.ready) || (dout.valid && dout.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no item accepted for %0d cycles", $time, QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		din.valid       = 1'b0;
		din.operation   = OP_SDEC;
		din.value       = '0;
		din.field_width = '0;
		din.zero_fill   = 1'b0;
		din.hex_prefix  = 1'b0;
		calm            = 1'b0;
		arst_n          = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// zero value prints one digit
		send_item(OP_SDEC, 32'h0, 6'd0, 1'b0, 1'b0);
		send_item(OP_UDEC, 32'h0, 6'd1, 1'b1, 1'b0);
		send_item(OP_HEXL, 32'h0, 6'd0, 1'b0, 1'b0);
		// most negative signed value, bare, zero padded and space padded past saturation
		send_item(OP_SDEC, 32'h8000_0000, 6'd0, 1'b0, 1'b0);
		send_item(OP_SDEC, 32'h8000_0000, 6'd20, 1'b1, 1'b0);
		send_item(OP_SDEC, 32'h8000_0000, 6'd63, 1'b0, 1'b0);
		// minus sign placement: after spaces, ahead of zeros
		send_item(OP_SDEC, 32'hffff_fffb, 6'd8, 1'b0, 1'b0);
		send_item(OP_SDEC, 32'hffff_fffb, 6'd8, 1'b1, 1'b0);
		send_item(OP_SDEC, 32'hffff_ffff, 6'd33, 1'b1, 1'b0);
		send_item(OP_SDEC, 32'h7fff_ffff, 6'd0, 1'b0, 1'b0);
		// unsigned extremes, saturated width and a field narrower than the number
		send_item(OP_UDEC, 32'hffff_ffff, 6'd0, 1'b0, 1'b0);
		send_item(OP_UDEC, 32'hffff_ffff, 6'd63, 1'b1, 1'b1);
		send_item(OP_UDEC, 32'd12345, 6'd3, 1'b1, 1'b0);
		// prefix flag has no effect on decimal
		send_item(OP_SDEC, 32'd42, 6'd5, 1'b0, 1'b1);
		send_item(OP_UDEC, 32'd7, 6'd10, 1'b1, 1'b1);
		// hex: both cases, prefix, spaces after the prefix, zeros, longest output
		send_item(OP_HEXL, 32'hdead_beef, 6'd0, 1'b0, 1'b0);
		send_item(OP_HEXU, 32'hdead_beef, 6'd0, 1'b0, 1'b1);
		send_item(OP_HEXL, 32'h0000_00ff, 6'd7, 1'b0, 1'b1);
		send_item(OP_HEXU, 32'h0000_00ff, 6'd7, 1'b1, 1'b1);
		send_item(OP_HEXU, 32'h0, 6'd63, 1'b0, 1'b1);
		send_item(OP_HEXL, 32'hffff_ffff, 6'd32, 1'b1, 1'b1);
		send_item(OP_HEXL, 32'h0123_abcd, 6'd8, 1'b0, 1'b0);
		send_item(OP_HEXU, 32'h89ab_cdef, 6'd2, 1'b1, 1'b0);
		wait_drained();

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			// every so often a stretch with no gaps and no stalls
			if (k % 30 == 0)
				calm = ($urandom_range(0, 3) == 0);
			// sender holds off until the block has emptied
			if (k == RANDOM_ITEMS / 2)
				wait_drained();
			send_item(op_t'($urandom_range(0, 3)), pick_value(), pick_width(),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
